FILE: hw/rtl/xtea_ctr_pkg.sv
// Shared types and constants for the XTEA counter-mode keystream block.
// No dependencies; imported by the front end, the cipher engine and the top level.
package xtea_ctr_pkg;

	localparam int DATA_W      = 64;
	localparam int HALF_W      = 32;
	localparam int NBYTES      = 8;
	localparam int NKEYS       = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [HALF_W-1:0] XTEA_DELTA = 32'h9E3779B9;
	localparam int KEY_SEL_SHIFT = 11;
	localparam int MIX_SHL       = 4;
	localparam int MIX_SHR       = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE = 3'd4;

	typedef logic [NKEYS-1:0][HALF_W-1:0] key_t;

	// One classified item on its way from the front end to the cipher engine.
	typedef struct packed {
		logic [DATA_W-1:0] ctr;
		logic [DATA_W-1:0] data;
		logic [NBYTES-1:0] byte_en;
		logic              bypass;
	} work_t;

endpackage

FILE: hw/rtl/xtea_ctr_fifo.sv
// Small first-word-fall-through queue built from flip-flops.
// No package dependencies; DEPTH must be a power of two.
module xtea_ctr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/xtea_ctr_front.sv
// Front end: accepts data words, keeps the block counter and builds work entries.
// Depends on xtea_ctr_pkg.
module xtea_ctr_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [xtea_ctr_pkg::DATA_W-1:0]       data_word,
	input  logic [3:0]                            valid_bytes,
	input  logic                                  start_message,
	input  logic [xtea_ctr_pkg::DATA_W-1:0]       start_nonce,
	input  logic                                  wq_full,
	output logic                                  wq_push,
	output xtea_ctr_pkg::work_t                   wq_wdata
);
	import xtea_ctr_pkg::*;

	logic [DATA_W-1:0] ctr_q;
	logic [DATA_W-1:0] ctr_use;
	logic [3:0]        nbytes;
	logic [NBYTES-1:0] byte_en;
	logic              bypass;

	assign full    = wq_full;
	assign wq_push = push && !wq_full;

	// A start reloads the counter; a zero nonce stands for one.
	assign ctr_use = start_message
		? ((start_nonce == '0) ? DATA_W'(1) : start_nonce)
		: ctr_q;

	// Counts above eight saturate to a full word.
	assign nbytes = valid_bytes[3] ? 4'd8 : valid_bytes;
	assign bypass = (nbytes == 4'd0);

	always_comb begin
		for (int i = 0; i < NBYTES; i++) begin
			byte_en[i] = (4'(i) < nbytes);
		end
	end

	assign wq_wdata = '{ctr: ctr_use, data: data_word, byte_en: byte_en, bypass: bypass};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (wq_push) begin
			ctr_q <= bypass ? ctr_use : ctr_use + DATA_W'(1);
		end
	end

endmodule

FILE: hw/rtl/xtea_ctr_core.sv
// Back end: iterative XTEA engine, one full round per cycle, plus the final byte-masked XOR.
// Depends on xtea_ctr_pkg.
module xtea_ctr_core #(
	parameter int ROUNDS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  xtea_ctr_pkg::key_t                key,
	input  xtea_ctr_pkg::work_t               wq_rdata,
	input  logic                              wq_empty,
	output logic                              wq_pop,
	input  logic                              rq_full,
	output logic                              rq_push,
	output logic [xtea_ctr_pkg::DATA_W-1:0]   rq_wdata
);
	import xtea_ctr_pkg::*;

	localparam int RW = $clog2(ROUNDS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [RW-1:0]     rnd_q;
	logic [HALF_W-1:0] v0_q;
	logic [HALF_W-1:0] v1_q;
	logic [HALF_W-1:0] sum_q;
	logic [DATA_W-1:0] data_q;
	logic [NBYTES-1:0] en_q;

	logic [HALF_W-1:0] ka;
	logic [HALF_W-1:0] kb;
	logic [HALF_W-1:0] v0_n;
	logic [HALF_W-1:0] v1_n;
	logic [DATA_W-1:0] mask;
	logic              last_rnd;

	// The round sum is advanced before the round, so sum_q already holds this round's value.
	assign ka   = sum_q + key[sum_q[1:0]];
	assign kb   = sum_q + key[2'(sum_q >> KEY_SEL_SHIFT)];
	assign v0_n = v0_q + ((((v1_q << MIX_SHL) ^ (v1_q >> MIX_SHR)) + v1_q) ^ ka);
	assign v1_n = v1_q + ((((v0_n << MIX_SHL) ^ (v0_n >> MIX_SHR)) + v0_n) ^ kb);

	assign last_rnd = (rnd_q == RW'(ROUNDS - 1));

	always_comb begin
		for (int i = 0; i < NBYTES; i++) begin
			mask[i*8 +: 8] = {8{en_q[i]}};
		end
	end

	assign wq_pop   = (state_q == ST_IDLE) && !wq_empty;
	assign rq_push  = (state_q == ST_DONE) && !rq_full;
	assign rq_wdata = (data_q ^ {v1_q, v0_q}) & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (wq_pop) begin
						state_q <= wq_rdata.bypass ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + RW'(1);
					if (last_rnd) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rq_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wq_pop) begin
			v0_q   <= wq_rdata.ctr[HALF_W-1:0];
			v1_q   <= wq_rdata.ctr[DATA_W-1:HALF_W];
			sum_q  <= XTEA_DELTA;
			data_q <= wq_rdata.data;
			en_q   <= wq_rdata.byte_en;
		end else if (state_q == ST_RUN) begin
			v0_q  <= v0_n;
			v1_q  <= v1_n;
			sum_q <= sum_q + XTEA_DELTA;
		end
	end

endmodule

FILE: hw/rtl/xtea_ctr_keystream_xor.sv
// Top level of the XTEA counter-mode keystream XOR block.
// Depends on xtea_ctr_pkg, xtea_ctr_fifo, xtea_ctr_front and xtea_ctr_core.
//
// Usage. Data words enter through a queue-style port: a transaction takes place
// at a rising edge with push high and full low. Each word carries up to eight
// bytes (valid_bytes, low byte first) and a start_message flag that reloads the
// block counter from the nonce register (a zero nonce loads one). Results leave
// through a second queue-style port: out_word is valid while empty is low and
// is taken at an edge with pop high. Exactly one result comes out per word, in
// order. Keys and nonce are written over the cfg port (cfg_ready is always high)
// while no word is in flight.
// Timing. The front end classifies a word and updates the counter in the cycle
// it is taken, so words queue up at once. The cipher engine runs one XTEA round
// per cycle: a word with at least one valid byte occupies it through a load
// step, ROUNDS rounds and a hand-off step, and it takes no new word until the
// hand-off is done, so that engine sets the sustained rate. A word with no valid
// bytes skips the rounds and goes from the load straight to the hand-off.
// Reset clears the counter to zero, the keys to zero, the nonce to one and both
// queues. When the receiver stalls, finished results collect in the output
// queue, then the engine holds its result, then the input queue fills and full
// rises; nothing is dropped.
module xtea_ctr_keystream_xor #(
	parameter int ROUNDS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [xtea_ctr_pkg::DATA_W-1:0]        data_word,
	input  logic [3:0]                             valid_bytes,
	input  logic                                   start_message,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [xtea_ctr_pkg::DATA_W-1:0]        out_word,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [xtea_ctr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [xtea_ctr_pkg::DATA_W-1:0]        cfg_data
);
	import xtea_ctr_pkg::*;

	key_t              key_q;
	logic [DATA_W-1:0] nonce_q;

	logic              wq_push;
	logic              wq_full;
	logic              wq_pop;
	logic              wq_empty;
	work_t             wq_wdata;
	work_t             wq_rdata;

	logic              rq_push;
	logic              rq_full;
	logic [DATA_W-1:0] rq_wdata;

	// The register file accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= DATA_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index) inside
				REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
					key_q[cfg_index[1:0]] <= cfg_data[HALF_W-1:0];
				end
				REG_NONCE: begin
					nonce_q <= cfg_data;
				end
				default: begin
					// Writes to unused indexes are ignored.
				end
			endcase
		end
	end

	// Front end: counter handling and byte-enable generation.
	xtea_ctr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_word     (data_word),
		.valid_bytes   (valid_bytes),
		.start_message (start_message),
		.start_nonce   (nonce_q),
		.wq_full       (wq_full),
		.wq_push       (wq_push),
		.wq_wdata      (wq_wdata)
	);

	// Work queue decouples the front end from the cipher engine.
	xtea_ctr_fifo #(
		.WIDTH ($bits(work_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.wdata  (wq_wdata),
		.full   (wq_full),
		.pop    (wq_pop),
		.rdata  (wq_rdata),
		.empty  (wq_empty)
	);

	xtea_ctr_core #(
		.ROUNDS (ROUNDS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.wq_rdata (wq_rdata),
		.wq_empty (wq_empty),
		.wq_pop   (wq_pop),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.rq_wdata (rq_wdata)
	);

	// Result queue drives the output port directly.
	xtea_ctr_fifo #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (out_word),
		.empty  (empty)
	);

	// The engine never hands a result to a full result queue.
	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> !rq_full)
		else $error("result pushed into a full result queue");

	// The engine only takes work that is actually queued.
	a_work_present: assert property (@(posedge clk) disable iff (!arst_n)
		wq_pop |-> !wq_empty)
		else $error("work queue popped while empty");

	// An accepted word is visible to the engine in the following cycle.
	a_work_visible: assert property (@(posedge clk) disable iff (!arst_n)
		wq_push |=> !wq_empty)
		else $error("accepted word missing from work queue");

endmodule
